@@ src/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for the pressure/temperature compensator
// Field widths, derived datapath widths, microcode control word and program ROM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

	localparam int RAW_W      = 24;
	localparam int COEF_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int TEMP_OUT_W = 21;
	localparam int P_OUT_W    = 23;

	localparam int SENS_SHIFT     = 15;
	localparam int OFF_SHIFT      = 17;
	localparam int SENS_TC_SHIFT  = 7;
	localparam int OFF_TC_SHIFT   = 5;
	localparam int TREF_SHIFT     = 7;
	localparam int TEMPSENS_SHIFT = 21;

	localparam int TEMP_BASE   = 2000;
	localparam int PROD_SHIFT  = 21;
	localparam int PRESS_SHIFT = 15;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// dT, signed, and its magnitude (also the multiplier's A width)
	localparam int DT_W    = imax(RAW_W, COEF_W + TREF_SHIFT) + 1;
	localparam int MUL_A_W = DT_W - 1;
	// sensitivity, signed; its magnitude is split into two multiplier halves
	localparam int SENS_W  = imax(COEF_W + SENS_SHIFT, COEF_W + MUL_A_W - SENS_TC_SHIFT) + 2;
	localparam int MUL_B_W = imax(COEF_W, SENS_W / 2);
	localparam int SMAG_W  = 2 * MUL_B_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W + MUL_B_W;
	localparam int SP_W    = ACC_W - PROD_SHIFT + 1;
	localparam int OFF_W   = imax(COEF_W + OFF_SHIFT, COEF_W + MUL_A_W - OFF_TC_SHIFT) + 2;
	localparam int DIFF_W  = imax(SP_W, OFF_W) + 1;
	localparam int TEMP_W  = imax(PROD_W - TEMPSENS_SHIFT + 2, TEMP_OUT_W + 1);
	localparam int P_W     = imax(DIFF_W - PRESS_SHIFT + 1, P_OUT_W + 1);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SENS_COEF      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_COEF    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMPCO    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMPCO  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP_COEF  = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENS_COEF = CFG_IDX_W'(5);

	localparam int PROG_LEN = 13;
	localparam int STEP_W   = $clog2(PROG_LEN);

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_DT,
		OP_TEMP,
		OP_OFF,
		OP_SENS,
		OP_SNEG,
		OP_ACC_LO,
		OP_ACC_HI,
		OP_SP,
		OP_DIFF,
		OP_OUT
	} op_t;

	typedef enum logic {
		MA_DT,
		MA_PP
	} ma_sel_t;

	typedef enum logic [2:0] {
		MB_NONE,
		MB_TSC,
		MB_OTC,
		MB_STC,
		MB_SLO,
		MB_SHI
	} mb_sel_t;

	typedef enum logic {
		JMP_NONE,
		JMP_SENS_POS
	} jmp_t;

	typedef struct packed {
		op_t     op;
		ma_sel_t ma;
		mb_sel_t mb;
		jmp_t    jmp;
		step_t   tgt;
		logic    last;
	} ctrl_t;

	typedef struct packed {
		logic [COEF_W-1:0] sens_coef;
		logic [COEF_W-1:0] offset_coef;
		logic [COEF_W-1:0] sens_tempco;
		logic [COEF_W-1:0] offset_tempco;
		logic [COEF_W-1:0] ref_temp_coef;
		logic [COEF_W-1:0] temp_sens_coef;
	} cfg_t;

	typedef struct packed {
		logic [TEMP_OUT_W-1:0] temperature;
		logic [P_OUT_W-1:0]    pressure;
		logic                  clipped;
	} res_t;

	// microcode program: one control word per step
	function automatic ctrl_t prog_rom(input step_t s);
		ctrl_t c;
		c.op   = OP_NOP;
		c.ma   = MA_DT;
		c.mb   = MB_NONE;
		c.jmp  = JMP_NONE;
		c.tgt  = '0;
		c.last = 1'b0;
		unique case (s)
			STEP_W'(0): c.op = OP_DT;
			STEP_W'(1): begin
				c.ma = MA_DT;
				c.mb = MB_TSC;
			end
			STEP_W'(2): begin
				c.ma = MA_DT;
				c.mb = MB_OTC;
				c.op = OP_TEMP;
			end
			STEP_W'(3): begin
				c.ma = MA_DT;
				c.mb = MB_STC;
				c.op = OP_OFF;
			end
			STEP_W'(4): c.op = OP_SENS;
			STEP_W'(5): begin
				c.jmp = JMP_SENS_POS;
				c.tgt = STEP_W'(7);
			end
			STEP_W'(6): c.op = OP_SNEG;
			STEP_W'(7): begin
				c.ma = MA_PP;
				c.mb = MB_SLO;
			end
			STEP_W'(8): begin
				c.ma = MA_PP;
				c.mb = MB_SHI;
				c.op = OP_ACC_LO;
			end
			STEP_W'(9):  c.op = OP_ACC_HI;
			STEP_W'(10): c.op = OP_SP;
			STEP_W'(11): c.op = OP_DIFF;
			STEP_W'(12): begin
				c.op   = OP_OUT;
				c.last = 1'b1;
			end
			default: c.last = 1'b1;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ src/pressure_temp_compensator_top.sv @@
// ----------------------------------------------------------------------------
// pressure_temp_compensator_top: raw pressure/temperature compensation
// The result is loaded by the final program step; a negative sensitivity adds one
// step. A new input is taken only after the program on the shared multiplier ends.
// Reset: async low clears coefficients, last readings and valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pressure_temp_compensator_top (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration write port
	input  wire                                  cfg_wen,
	input  wire [ptc_pkg::CFG_IDX_W-1:0]         cfg_addr,
	input  wire [ptc_pkg::COEF_W-1:0]            cfg_wdata,
	// input channel
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire                                  sample_kind,
	input  wire [ptc_pkg::RAW_W-1:0]             raw_value,
	// output channel
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [ptc_pkg::TEMP_OUT_W-1:0] temperature_centi,
	output logic signed [ptc_pkg::P_OUT_W-1:0]    pressure_out,
	output logic                                 not_ready,
	output logic                                 saturated
);

	// Flow: an input transfer stores the reading as the latest of its kind and
	// starts the microcode program. The program runs dT, temperature, offset,
	// sensitivity and the pressure product on one multiplier, then loads the
	// output register. A new input is taken as soon as the program finishes,
	// even while the previous result still waits in the output register; the
	// final step holds only if that register is still full.

	ptc_pkg::cfg_t                 cfg_q;
	logic [ptc_pkg::RAW_W-1:0]     press_raw_q;
	logic [ptc_pkg::RAW_W-1:0]     temp_raw_q;
	logic                          zero_raw_q;

	logic                          out_valid_q;
	logic [ptc_pkg::TEMP_OUT_W-1:0] temp_out_q;
	logic [ptc_pkg::P_OUT_W-1:0]   press_out_q;
	logic                          not_ready_q;
	logic                          saturated_q;

	logic                          in_xfer;
	logic                          busy;
	logic                          ctrl_en;
	logic                          sens_neg;
	logic                          load_out;
	ptc_pkg::ctrl_t                ctrl;
	ptc_pkg::res_t                 res;

	assign in_ready = !busy;
	assign in_xfer  = in_valid && in_ready;
	assign load_out = ctrl_en && (ctrl.op == ptc_pkg::OP_OUT);

	// Configuration registers; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				ptc_pkg::REG_SENS_COEF:      cfg_q.sens_coef      <= cfg_wdata;
				ptc_pkg::REG_OFFSET_COEF:    cfg_q.offset_coef    <= cfg_wdata;
				ptc_pkg::REG_SENS_TEMPCO:    cfg_q.sens_tempco    <= cfg_wdata;
				ptc_pkg::REG_OFFSET_TEMPCO:  cfg_q.offset_tempco  <= cfg_wdata;
				ptc_pkg::REG_REF_TEMP_COEF:  cfg_q.ref_temp_coef  <= cfg_wdata;
				ptc_pkg::REG_TEMP_SENS_COEF: cfg_q.temp_sens_coef <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Latest readings: a missing reading counts as zero after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_raw_q <= '0;
			temp_raw_q  <= '0;
		end else if (in_xfer) begin
			if (sample_kind) begin
				temp_raw_q <= raw_value;
			end else begin
				press_raw_q <= raw_value;
			end
		end
	end

	// Zero reading marks the result as not ready; computed regardless.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			zero_raw_q <= (raw_value == '0);
		end
	end

	ptc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_xfer),
		.stall    (out_valid_q && !out_ready),
		.sens_neg (sens_neg),
		.busy     (busy),
		.ctrl_en  (ctrl_en),
		.ctrl     (ctrl)
	);

	ptc_dp u_dp (
		.clk       (clk),
		.en        (ctrl_en),
		.ctrl      (ctrl),
		.cfg       (cfg_q),
		.press_raw (press_raw_q),
		.temp_raw  (temp_raw_q),
		.sens_neg  (sens_neg),
		.res       (res)
	);

	// Output register: fill on the last program step, drain on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			temp_out_q  <= res.temperature;
			press_out_q <= res.pressure;
			not_ready_q <= zero_raw_q;
			saturated_q <= res.clipped;
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = $signed(temp_out_q);
	assign pressure_out      = $signed(press_out_q);
	assign not_ready         = not_ready_q;
	assign saturated         = saturated_q;

endmodule

`default_nettype wire

@@ src/ptc_seq.sv @@
// ----------------------------------------------------------------------------
// ptc_seq: microcode sequencer
// Step counter over the program ROM with one conditional jump and a final hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptc_seq (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  wire             stall,
	input  wire             sens_neg,
	output logic            busy,
	output logic            ctrl_en,
	output ptc_pkg::ctrl_t  ctrl
);

	logic                busy_q;
	ptc_pkg::step_t      step_q;
	logic                hold;
	logic                take_jump;

	assign ctrl      = ptc_pkg::prog_rom(step_q);
	// hold the last step while the result register is still occupied
	assign hold      = stall && ctrl.last;
	assign ctrl_en   = busy_q && !hold;
	assign busy      = busy_q;
	assign take_jump = (ctrl.jmp == ptc_pkg::JMP_SENS_POS) && !sens_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (ctrl_en) begin
			if (ctrl.last) begin
				busy_q <= 1'b0;
			end else if (take_jump) begin
				step_q <= ctrl.tgt;
			end else begin
				step_q <= step_q + ptc_pkg::STEP_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ src/ptc_dp.sv @@
// ----------------------------------------------------------------------------
// ptc_dp: compensation datapath
// One shared unsigned multiplier, sign/magnitude terms, accumulator and clamps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptc_dp (
	input  wire                              clk,
	input  wire                              en,
	input  wire ptc_pkg::ctrl_t              ctrl,
	input  wire ptc_pkg::cfg_t               cfg,
	input  wire [ptc_pkg::RAW_W-1:0]         press_raw,
	input  wire [ptc_pkg::RAW_W-1:0]         temp_raw,
	output logic                             sens_neg,
	output ptc_pkg::res_t                    res
);

	localparam int DT_W    = ptc_pkg::DT_W;
	localparam int MUL_A_W = ptc_pkg::MUL_A_W;
	localparam int MUL_B_W = ptc_pkg::MUL_B_W;
	localparam int SMAG_W  = ptc_pkg::SMAG_W;
	localparam int PROD_W  = ptc_pkg::PROD_W;
	localparam int ACC_W   = ptc_pkg::ACC_W;
	localparam int SENS_W  = ptc_pkg::SENS_W;
	localparam int SP_W    = ptc_pkg::SP_W;
	localparam int OFF_W   = ptc_pkg::OFF_W;
	localparam int DIFF_W  = ptc_pkg::DIFF_W;
	localparam int TEMP_W  = ptc_pkg::TEMP_W;
	localparam int P_W     = ptc_pkg::P_W;
	localparam int TO_W    = ptc_pkg::TEMP_OUT_W;
	localparam int PO_W    = ptc_pkg::P_OUT_W;

	localparam int PRND  = (1 << ptc_pkg::PRESS_SHIFT) - 1;
	localparam int TMAXI = (1 << (TO_W - 1)) - 1;
	localparam int PMAXI = (1 << (PO_W - 1)) - 1;
	localparam logic signed [TEMP_W-1:0] T_MAX_C = TEMP_W'(TMAXI);
	localparam logic signed [TEMP_W-1:0] T_MIN_C = TEMP_W'(-TMAXI - 1);
	localparam logic signed [P_W-1:0]    P_MAX_C = P_W'(PMAXI);
	localparam logic signed [P_W-1:0]    P_MIN_C = P_W'(-PMAXI - 1);

	logic [MUL_A_W-1:0]        dt_mag_q;
	logic                      dt_neg_q;
	logic [PROD_W-1:0]         prod_q;
	logic signed [TEMP_W-1:0]  temp_q;
	logic signed [OFF_W-1:0]   off_q;
	logic signed [SENS_W-1:0]  sens_q;
	logic [SMAG_W-1:0]         smag_q;
	logic [ACC_W-1:0]          acc_q;
	logic signed [SP_W-1:0]    sp_q;
	logic signed [DIFF_W-1:0]  diff_q;

	logic signed [DT_W-1:0]    dt_c;
	logic [MUL_A_W-1:0]        mul_a;
	logic [MUL_B_W-1:0]        mul_b;
	logic signed [TEMP_W-1:0]  t_term;
	logic signed [TEMP_W-1:0]  temp_c;
	logic signed [OFF_W-1:0]   o_base;
	logic signed [OFF_W-1:0]   o_term;
	logic signed [OFF_W-1:0]   off_c;
	logic signed [SENS_W-1:0]  s_base;
	logic signed [SENS_W-1:0]  s_term;
	logic signed [SENS_W-1:0]  sens_c;
	logic signed [SP_W-1:0]    sp_mag;
	logic signed [DIFF_W-1:0]  diff_adj;
	logic signed [DIFF_W-1:0]  p_shr;
	logic signed [P_W-1:0]     p_c;

	assign dt_c = $signed(DT_W'(temp_raw))
		- $signed(DT_W'(cfg.ref_temp_coef) << ptc_pkg::TREF_SHIFT);

	// temperature-dependent terms: magnitude product, then sign of dT
	assign t_term = $signed(TEMP_W'(prod_q >> ptc_pkg::TEMPSENS_SHIFT));
	assign temp_c = TEMP_W'(ptc_pkg::TEMP_BASE) + (dt_neg_q ? -t_term : t_term);

	assign o_base = $signed(OFF_W'(cfg.offset_coef) << ptc_pkg::OFF_SHIFT);
	assign o_term = $signed(OFF_W'(prod_q >> ptc_pkg::OFF_TC_SHIFT));
	assign off_c  = o_base + (dt_neg_q ? -o_term : o_term);

	assign s_base = $signed(SENS_W'(cfg.sens_coef) << ptc_pkg::SENS_SHIFT);
	assign s_term = $signed(SENS_W'(prod_q >> ptc_pkg::SENS_TC_SHIFT));
	assign sens_c = s_base + (dt_neg_q ? -s_term : s_term);

	assign sens_neg = sens_q[SENS_W-1];
	assign sp_mag   = $signed(SP_W'(acc_q >> ptc_pkg::PROD_SHIFT));

	// divide by 2^PRESS_SHIFT rounding toward zero
	assign diff_adj = diff_q + (diff_q[DIFF_W-1] ? DIFF_W'(PRND) : DIFF_W'(0));
	assign p_shr    = diff_adj >>> ptc_pkg::PRESS_SHIFT;
	assign p_c      = P_W'(p_shr);

	always_comb begin
		mul_a = (ctrl.ma == ptc_pkg::MA_PP) ? MUL_A_W'(press_raw) : dt_mag_q;
		unique case (ctrl.mb)
			ptc_pkg::MB_TSC: mul_b = MUL_B_W'(cfg.temp_sens_coef);
			ptc_pkg::MB_OTC: mul_b = MUL_B_W'(cfg.offset_tempco);
			ptc_pkg::MB_STC: mul_b = MUL_B_W'(cfg.sens_tempco);
			ptc_pkg::MB_SLO: mul_b = smag_q[MUL_B_W-1:0];
			ptc_pkg::MB_SHI: mul_b = smag_q[SMAG_W-1:MUL_B_W];
			default:         mul_b = '0;
		endcase
	end

	always_comb begin
		res.clipped = 1'b0;
		if (temp_q < T_MIN_C) begin
			res.temperature = T_MIN_C[TO_W-1:0];
			res.clipped     = 1'b1;
		end else if (temp_q > T_MAX_C) begin
			res.temperature = T_MAX_C[TO_W-1:0];
			res.clipped     = 1'b1;
		end else begin
			res.temperature = temp_q[TO_W-1:0];
		end
		if (p_c < P_MIN_C) begin
			res.pressure = P_MIN_C[PO_W-1:0];
			res.clipped  = 1'b1;
		end else if (p_c > P_MAX_C) begin
			res.pressure = P_MAX_C[PO_W-1:0];
			res.clipped  = 1'b1;
		end else begin
			res.pressure = p_c[PO_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
			case (ctrl.op)
				ptc_pkg::OP_DT: begin
					dt_neg_q <= dt_c[DT_W-1];
					dt_mag_q <= dt_c[DT_W-1] ? MUL_A_W'(-dt_c) : MUL_A_W'(dt_c);
				end
				ptc_pkg::OP_TEMP: temp_q <= temp_c;
				ptc_pkg::OP_OFF:  off_q  <= off_c;
				ptc_pkg::OP_SENS: begin
					sens_q <= sens_c;
					smag_q <= SMAG_W'(sens_c);
				end
				ptc_pkg::OP_SNEG:   smag_q <= SMAG_W'(-sens_q);
				ptc_pkg::OP_ACC_LO: acc_q  <= ACC_W'(prod_q);
				ptc_pkg::OP_ACC_HI: acc_q  <= acc_q + (ACC_W'(prod_q) << MUL_B_W);
				ptc_pkg::OP_SP:     sp_q   <= sens_neg ? -sp_mag : sp_mag;
				ptc_pkg::OP_DIFF:   diff_q <= DIFF_W'(sp_q) - DIFF_W'(off_q);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: regression for pressure_temp_compensator_top
// Drives raw pressure and temperature readings through the valid/ready input
// channel under several coefficient sets, mirrors the compensation math in a
// local predictor, and checks every output transfer field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import ptc_pkg::*;

	// sample kinds on the input channel
	localparam logic KIND_PRESSURE = 1'b0;
	localparam logic KIND_TEMP     = 1'b1;

	// register indexes beyond the last coefficient; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

	localparam logic [CFG_IDX_W-1:0] COEF_REGS [6] = '{
		REG_SENS_COEF, REG_OFFSET_COEF, REG_SENS_TEMPCO,
		REG_OFFSET_TEMPCO, REG_REF_TEMP_COEF, REG_TEMP_SENS_COEF
	};

	localparam longint TEMP_LO  = -(longint'(1) <<< (TEMP_OUT_W - 1));
	localparam longint TEMP_HI  = (longint'(1) <<< (TEMP_OUT_W - 1)) - 1;
	localparam longint PRESS_LO = -(longint'(1) <<< (P_OUT_W - 1));
	localparam longint PRESS_HI = (longint'(1) <<< (P_OUT_W - 1)) - 1;

	localparam int RAND_PHASES      = 6;
	localparam int READINGS_PER_SET = 250;
	localparam int SETTLE_CYCLES    = 20;

	typedef struct packed {
		logic [TEMP_OUT_W-1:0] temp;
		logic [P_OUT_W-1:0]    press;
		logic                  nr;
		logic                  sat;
	} reading_result_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             row;
		logic [CFG_IDX_W-1:0]  idx;
		logic                  kind;
		logic [RAW_W-1:0]      value;
		logic                  typed;
		reading_result_t       res;
	} stim_row_t;

	// with all coefficients zero every reading gives 20.00 degrees and zero pressure
	localparam reading_result_t AT_BASE    = '{TEMP_OUT_W'(2000), '0, 1'b0, 1'b0};
	localparam reading_result_t AT_BASE_NR = '{TEMP_OUT_W'(2000), '0, 1'b1, 1'b0};
	localparam reading_result_t NO_RES     = '0;

	localparam stim_row_t DIRECTED_ROWS [0:36] = '{
		// before any coefficient write, starting before any reading of the other kind
		'{ROW_ITEM, REG_SENS_COEF, KIND_PRESSURE, 24'h000000, 1'b1, AT_BASE_NR},
		'{ROW_ITEM, REG_SENS_COEF, KIND_TEMP,     24'h000000, 1'b1, AT_BASE_NR},
		'{ROW_ITEM, REG_SENS_COEF, KIND_PRESSURE, 24'hFFFFFF, 1'b1, AT_BASE},
		'{ROW_ITEM, REG_SENS_COEF, KIND_TEMP,     24'hFFFFFF, 1'b1, AT_BASE},
		// every coefficient at full scale; spare indexes must not disturb them
		'{ROW_CFG, REG_SENS_COEF,      KIND_PRESSURE, 24'h00FFFF, 1'b0, NO_RES},
		'{ROW_CFG, REG_OFFSET_COEF,    KIND_PRESSURE, 24'h00FFFF, 1'b0, NO_RES},
		'{ROW_CFG, REG_SENS_TEMPCO,    KIND_PRESSURE, 24'h00FFFF, 1'b0, NO_RES},
		'{ROW_CFG, REG_OFFSET_TEMPCO,  KIND_PRESSURE, 24'h00FFFF, 1'b0, NO_RES},
		'{ROW_CFG, REG_REF_TEMP_COEF,  KIND_PRESSURE, 24'h00FFFF, 1'b0, NO_RES},
		'{ROW_CFG, REG_TEMP_SENS_COEF, KIND_PRESSURE, 24'h00FFFF, 1'b0, NO_RES},
		'{ROW_CFG, REG_SPARE_HI,       KIND_PRESSURE, 24'h000000, 1'b0, NO_RES},
		'{ROW_CFG, REG_SPARE_LO,       KIND_PRESSURE, 24'h001234, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_TEMP,     24'h000000, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_PRESSURE, 24'hFFFFFF, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_TEMP,     24'hFFFFFF, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_PRESSURE, 24'h000001, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_PRESSURE, 24'h000000, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_TEMP,     24'h000001, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_TEMP,     24'h800000, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_PRESSURE, 24'h800000, 1'b0, NO_RES},
		// only the temperature coefficients left: sensitivity rides on dT alone
		'{ROW_CFG, REG_SENS_COEF,     KIND_PRESSURE, 24'h000000, 1'b0, NO_RES},
		'{ROW_CFG, REG_OFFSET_COEF,   KIND_PRESSURE, 24'h000000, 1'b0, NO_RES},
		'{ROW_CFG, REG_REF_TEMP_COEF, KIND_PRESSURE, 24'h000000, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_TEMP,     24'hFFFFFF, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_PRESSURE, 24'hFFFFFF, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_TEMP,     24'h000000, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_PRESSURE, 24'h000000, 1'b0, NO_RES},
		// full base sensitivity, no temperature terms, highest reference
		'{ROW_CFG, REG_SENS_COEF,      KIND_PRESSURE, 24'h00FFFF, 1'b0, NO_RES},
		'{ROW_CFG, REG_OFFSET_COEF,    KIND_PRESSURE, 24'h000000, 1'b0, NO_RES},
		'{ROW_CFG, REG_SENS_TEMPCO,    KIND_PRESSURE, 24'h000000, 1'b0, NO_RES},
		'{ROW_CFG, REG_OFFSET_TEMPCO,  KIND_PRESSURE, 24'h000000, 1'b0, NO_RES},
		'{ROW_CFG, REG_REF_TEMP_COEF,  KIND_PRESSURE, 24'h00FFFF, 1'b0, NO_RES},
		'{ROW_CFG, REG_TEMP_SENS_COEF, KIND_PRESSURE, 24'h000000, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_PRESSURE, 24'hFFFFFF, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_TEMP,     24'h555555, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_PRESSURE, 24'hAAAAAA, 1'b0, NO_RES},
		'{ROW_ITEM, REG_SENS_COEF, KIND_TEMP,     24'h000000, 1'b0, NO_RES}
	};

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         cfg_wen     = 1'b0;
	logic [CFG_IDX_W-1:0]         cfg_addr    = '0;
	logic [COEF_W-1:0]            cfg_wdata   = '0;
	logic                         in_valid    = 1'b0;
	logic                         in_ready;
	logic                         sample_kind = 1'b0;
	logic [RAW_W-1:0]             raw_value   = '0;
	logic                         out_valid;
	logic                         out_ready   = 1'b0;
	logic signed [TEMP_OUT_W-1:0] temperature_centi;
	logic signed [P_OUT_W-1:0]    pressure_out;
	logic                         not_ready;
	logic                         saturated;

	// mirror of the block's coefficients and latest readings
	cfg_t             coef_mirror = '0;
	logic [RAW_W-1:0] last_press_raw = '0;
	logic [RAW_W-1:0] last_temp_raw  = '0;

	reading_result_t predicted_outputs [$];
	int              errors   = 0;
	int              idle_pct = 0;
	int unsigned     stall_left = 0;

	pressure_temp_compensator_top uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wen           (cfg_wen),
		.cfg_addr          (cfg_addr),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.sample_kind       (sample_kind),
		.raw_value         (raw_value),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature_centi (temperature_centi),
		.pressure_out      (pressure_out),
		.not_ready         (not_ready),
		.saturated         (saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// divide by 2^k, truncating toward zero
	function automatic longint trunc_div_pow2(input longint x, input int k);
		longint m;
		m = (x < 0) ? -x : x;
		m = m >> k;
		return (x < 0) ? -m : m;
	endfunction

	// store the reading, then compensate from the latest pair
	function automatic reading_result_t compensate_reading(input logic kind,
			input logic [RAW_W-1:0] raw);
		longint dt, temp, off, sens, press;
		reading_result_t r;
		if (kind == KIND_PRESSURE) begin
			last_press_raw = raw;
		end else begin
			last_temp_raw = raw;
		end
		dt = longint'(last_temp_raw) - (longint'(coef_mirror.ref_temp_coef) << TREF_SHIFT);
		temp = TEMP_BASE + trunc_div_pow2(dt * longint'(coef_mirror.temp_sens_coef),
			TEMPSENS_SHIFT);
		off = (longint'(coef_mirror.offset_coef) << OFF_SHIFT)
			+ trunc_div_pow2(longint'(coef_mirror.offset_tempco) * dt, OFF_TC_SHIFT);
		sens = (longint'(coef_mirror.sens_coef) << SENS_SHIFT)
			+ trunc_div_pow2(longint'(coef_mirror.sens_tempco) * dt, SENS_TC_SHIFT);
		// |sens| stays below 2^35 and the reading below 2^24, so the product fits
		press = trunc_div_pow2(trunc_div_pow2(sens * longint'(last_press_raw), PROD_SHIFT)
			- off, PRESS_SHIFT);
		r.sat = 1'b0;
		if (temp < TEMP_LO) begin
			temp = TEMP_LO;
			r.sat = 1'b1;
		end else if (temp > TEMP_HI) begin
			temp = TEMP_HI;
			r.sat = 1'b1;
		end
		if (press < PRESS_LO) begin
			press = PRESS_LO;
			r.sat = 1'b1;
		end else if (press > PRESS_HI) begin
			press = PRESS_HI;
			r.sat = 1'b1;
		end
		r.temp  = temp[TEMP_OUT_W-1:0];
		r.press = press[P_OUT_W-1:0];
		r.nr    = (raw == '0);
		return r;
	endfunction

	// one register write, then the enable is driven low again before the task returns
	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_SENS_COEF:      coef_mirror.sens_coef      = val;
			REG_OFFSET_COEF:    coef_mirror.offset_coef    = val;
			REG_SENS_TEMPCO:    coef_mirror.sens_tempco    = val;
			REG_OFFSET_TEMPCO:  coef_mirror.offset_tempco  = val;
			REG_REF_TEMP_COEF:  coef_mirror.ref_temp_coef  = val;
			REG_TEMP_SENS_COEF: coef_mirror.temp_sens_coef = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// hold the input side until every predicted output has been seen
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (predicted_outputs.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// one input transfer; a typed row supplies its own expected result
	task automatic send_reading(input logic kind, input logic [RAW_W-1:0] raw,
			input logic typed, input reading_result_t typed_res);
		reading_result_t r;
		if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sample_kind <= kind;
		raw_value   <= raw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = compensate_reading(kind, raw);
		predicted_outputs.push_back(typed ? typed_res : r);
	endtask

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw();
		logic [RAW_W-1:0] near_ref;
		near_ref = RAW_W'(coef_mirror.ref_temp_coef) << TREF_SHIFT;
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return RAW_W'($urandom_range(0, 255));
			3:       return near_ref + RAW_W'($urandom_range(0, 63)) - RAW_W'(32);
			default: return RAW_W'($urandom);
		endcase
	endfunction

	// output side: check each transfer, stall in short random bursts
	always @(posedge clk) begin : result_check
		reading_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_outputs.size() == 0) begin
				$error("unexpected output transfer: temperature_centi %0d pressure_out %0d",
					temperature_centi, pressure_out);
				errors++;
			end else begin
				want = predicted_outputs.pop_front();
				if (temperature_centi !== want.temp) begin
					$error("temperature_centi: expected %0d, got %0d",
						$signed(want.temp), temperature_centi);
					errors++;
				end
				if (pressure_out !== want.press) begin
					$error("pressure_out: expected %0d, got %0d",
						$signed(want.press), pressure_out);
					errors++;
				end
				if (not_ready !== want.nr) begin
					$error("not_ready: expected %0b, got %0b", want.nr, not_ready);
					errors++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %0b, got %0b", want.sat, saturated);
					errors++;
				end
			end
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
			stall_left <= $urandom_range(0, 4);
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#5_000_000;
		$display("pressure_temp_compensator_top regression: fail");
		$finish;
	end

	initial begin
		stim_row_t row;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows run with mild idling on both sides
		idle_pct = 20;
		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			if (row.row == ROW_CFG) begin
				// coefficients change only while nothing is in flight
				if (predicted_outputs.size() != 0 || in_valid) begin
					wait_for_results();
				end
				write_coef(row.idx, row.value[COEF_W-1:0]);
			end else begin
				send_reading(row.kind, row.value, row.typed, row.res);
			end
		end

		// random coefficient sets; one set and the final one run without idling
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			wait_for_results();
			idle_pct = (phase == 2 || phase == RAND_PHASES - 1) ? 0 : $urandom_range(10, 40);
			foreach (COEF_REGS[r]) begin
				write_coef(COEF_REGS[r], pick_coef());
			end
			if ($urandom_range(0, 1) == 1) begin
				write_coef($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, COEF_W'($urandom));
			end
			for (int n = 0; n < READINGS_PER_SET; n++) begin
				send_reading(1'($urandom), pick_raw(), 1'b0, NO_RES);
			end
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && predicted_outputs.size() == 0) begin
			$display("pressure_temp_compensator_top regression: pass");
		end else begin
			$display("pressure_temp_compensator_top regression: fail");
		end
		$finish;
	end

endmodule
